>>> rtl/atc_pkg.sv
// Shared types, widths and constants for the accelerometer tap classifier.
package atc_pkg;

	// Field widths
	localparam int SAMPLE_BITS = 16;
	localparam int TIME_BITS   = 32;

	// Configuration register widths and reset values
	localparam int GRAV_W     = 12;
	localparam int THR_W      = 12;
	localparam int COOL_W     = 16;
	localparam int LONG_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 2;

	localparam logic [GRAV_W-1:0] GRAVITY_RST   = GRAV_W'(1000);
	localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(1500);
	localparam logic [COOL_W-1:0] COOLDOWN_RST  = COOL_W'(200);
	localparam logic [LONG_W-1:0] LONG_TAP_RST  = LONG_W'(2000);

	// Magnitude arithmetic: squared raw counts against squared mg bounds
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int SUM_BITS    = 2 * SAMPLE_BITS;
	localparam int PROD_W      = 2 * SAMPLE_BITS + 16;
	localparam int MG_SHIFT    = 2 * (SAMPLE_BITS - 6);
	localparam int BND_W       = GRAV_W + 2;
	localparam int BND_SQ_W    = 2 * BND_W;
	localparam int SCALE_START = 15625;
	localparam int END_SHIFT   = 2;

	// Queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GRAVITY   = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_COOLDOWN  = 2'd2,
		REG_LONG_TAP  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic [TIME_BITS-1:0]          time_ms;
	} sample_t;

	typedef struct packed {
		logic tap_done;
		logic tap_short;
		logic tap_active;
	} result_t;

	// Classified sample handed from front to back
	typedef struct packed {
		logic                 start_cand;
		logic                 end_cand;
		logic [TIME_BITS-1:0] time_ms;
	} cls_t;

	// Squared, scaled magnitude bounds derived from configuration
	typedef struct packed {
		logic [PROD_W-1:0] over_sq;
		logic              under_en;
		logic [PROD_W-1:0] under_sq;
		logic [PROD_W-1:0] end_hi_sq;
		logic              end_lo_en;
		logic [PROD_W-1:0] end_lo_sq;
	} bounds_t;

	typedef struct packed {
		logic [COOL_W-1:0] cooldown_ms;
		logic [LONG_W-1:0] long_tap_ms;
	} timing_t;

endpackage

>>> rtl/accel_tap_classifier.sv
// A word passes stages s1, s2, s3, the mid queue, back stage and out queue.
// Throughput: one word per cycle sustained unless a queue fills; the front
// pipeline and the back-stage tap state loop each take one word per cycle.
// Reset: arst_n clears all queues, pipeline valids and tap state, and loads
// the configuration registers with their defaults; no warm-up pass follows.
// Top level of the accelerometer tap classifier.
module accel_tap_classifier #(
	parameter int MID_DEPTH = atc_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = atc_pkg::OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample side
	input  logic                           push,
	input  atc_pkg::sample_t               sample,
	output logic                           full,
	// result side
	output logic                           empty,
	input  logic                           pop,
	output atc_pkg::result_t               result,
	// configuration writes
	input  logic                           cfg_wr_en,
	input  atc_pkg::cfg_reg_t              cfg_addr,
	input  logic [atc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	atc_pkg::bounds_t bounds;
	atc_pkg::timing_t timing;

	atc_pkg::cls_t    cls_w;
	atc_pkg::cls_t    cls_r;
	logic             cls_push;
	logic             cls_full;
	logic             cls_pop;
	logic             cls_empty;

	atc_pkg::result_t res_w;
	logic             res_push;
	logic             res_full;

	// Configuration registers and the squared bounds they imply
	atc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.bounds    (bounds),
		.timing    (timing)
	);

	// Front: square the axes, sum, scale, classify against the bounds
	atc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.bounds   (bounds),
		.cls_push (cls_push),
		.cls      (cls_w),
		.cls_full (cls_full)
	);

	// Decouple classification from the tap state so either side may stall
	atc_fifo #(
		.WIDTH ($bits(atc_pkg::cls_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cls_push),
		.wdata  (cls_w),
		.full   (cls_full),
		.pop    (cls_pop),
		.rdata  (cls_r),
		.empty  (cls_empty)
	);

	// Back: advance the tap state one word at a time and form the result
	atc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_r),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.timing    (timing),
		.res_push  (res_push),
		.res       (res_w),
		.res_full  (res_full)
	);

	// Hold finished results until the consumer drains them
	atc_fifo #(
		.WIDTH ($bits(atc_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_w),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

>>> rtl/atc_fifo.sv
// Small show-ahead register queue.
module atc_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/atc_cfg.sv
// Configuration registers and the squared magnitude bounds derived from them.
module atc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  atc_pkg::cfg_reg_t                   cfg_addr,
	input  logic [atc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output atc_pkg::bounds_t                    bounds,
	output atc_pkg::timing_t                    timing
);
	logic [atc_pkg::GRAV_W-1:0] grav_q;
	logic [atc_pkg::THR_W-1:0]  thr_q;
	logic [atc_pkg::COOL_W-1:0] cool_q;
	logic [atc_pkg::LONG_W-1:0] long_q;

	logic [atc_pkg::BND_W-1:0] hi;
	logic [atc_pkg::BND_W-1:0] lo;
	logic [atc_pkg::BND_W-1:0] hi2;
	logic [atc_pkg::BND_W-1:0] twice_g;
	logic [atc_pkg::BND_W-1:0] lo2;
	atc_pkg::bounds_t          bounds_d;
	atc_pkg::bounds_t          bounds_q;

	// square a bound in mg and bring it to the raw-count scale
	function automatic logic [atc_pkg::PROD_W-1:0] scaled_sq(
		input logic [atc_pkg::BND_W-1:0] v
	);
		logic [atc_pkg::BND_SQ_W-1:0] sq;
		sq = atc_pkg::BND_SQ_W'(v) * atc_pkg::BND_SQ_W'(v);
		return atc_pkg::PROD_W'(sq) << atc_pkg::MG_SHIFT;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= atc_pkg::GRAVITY_RST;
			thr_q  <= atc_pkg::THRESHOLD_RST;
			cool_q <= atc_pkg::COOLDOWN_RST;
			long_q <= atc_pkg::LONG_TAP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				atc_pkg::REG_GRAVITY:   grav_q <= cfg_wdata[atc_pkg::GRAV_W-1:0];
				atc_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata[atc_pkg::THR_W-1:0];
				atc_pkg::REG_COOLDOWN:  cool_q <= cfg_wdata[atc_pkg::COOL_W-1:0];
				atc_pkg::REG_LONG_TAP:  long_q <= cfg_wdata[atc_pkg::LONG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		hi      = atc_pkg::BND_W'(grav_q) + atc_pkg::BND_W'(thr_q);
		lo      = atc_pkg::BND_W'(grav_q) - atc_pkg::BND_W'(thr_q);
		twice_g = atc_pkg::BND_W'(grav_q) << 1;
		hi2     = twice_g + atc_pkg::BND_W'(thr_q);
		lo2     = twice_g - atc_pkg::BND_W'(thr_q);

		bounds_d.over_sq   = scaled_sq(hi);
		bounds_d.under_en  = (grav_q > thr_q);
		bounds_d.under_sq  = scaled_sq(lo);
		bounds_d.end_hi_sq = scaled_sq(hi2);
		bounds_d.end_lo_en = !(twice_g < atc_pkg::BND_W'(thr_q));
		bounds_d.end_lo_sq = scaled_sq(lo2);
	end

	// Refresh every cycle; the bounds settle in the cycle after a register write
	always_ff @(posedge clk) begin
		bounds_q <= bounds_d;
	end

	assign bounds             = bounds_q;
	assign timing.cooldown_ms = cool_q;
	assign timing.long_tap_ms = long_q;

endmodule

>>> rtl/atc_front.sv
// Front pipeline: squares, sum, scaling and threshold classification of samples.
module atc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  atc_pkg::sample_t  sample,
	output logic              full,
	input  atc_pkg::bounds_t  bounds,
	output logic              cls_push,
	output atc_pkg::cls_t     cls,
	input  logic              cls_full
);
	logic en;
	logic accept;

	logic v_s1;
	logic v_s2;
	logic v_s3;

	logic signed [atc_pkg::SQ_BITS-1:0] ax;
	logic signed [atc_pkg::SQ_BITS-1:0] ay;
	logic signed [atc_pkg::SQ_BITS-1:0] az;

	logic [atc_pkg::SQ_BITS-1:0]   sq_x_s1;
	logic [atc_pkg::SQ_BITS-1:0]   sq_y_s1;
	logic [atc_pkg::SQ_BITS-1:0]   sq_z_s1;
	logic [atc_pkg::TIME_BITS-1:0] time_s1;
	logic [atc_pkg::SUM_BITS-1:0]  sum_s2;
	logic [atc_pkg::TIME_BITS-1:0] time_s2;
	logic [atc_pkg::PROD_W-1:0]    scaled_s3;
	logic [atc_pkg::TIME_BITS-1:0] time_s3;

	logic [atc_pkg::PROD_W-1:0] scaled_end;
	logic                       over;
	logic                       under;
	logic                       below_hi;
	logic                       above_lo;

	// Whole pipeline holds while the last stage cannot hand off
	assign en     = !(v_s3 && cls_full);
	assign full   = !en;
	assign accept = push && en;

	assign ax = atc_pkg::SQ_BITS'(sample.accel_x);
	assign ay = atc_pkg::SQ_BITS'(sample.accel_y);
	assign az = atc_pkg::SQ_BITS'(sample.accel_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1   <= $unsigned(ax * ax);
			sq_y_s1   <= $unsigned(ay * ay);
			sq_z_s1   <= $unsigned(az * az);
			time_s1   <= sample.time_ms;
			sum_s2    <= sq_x_s1 + sq_y_s1 + sq_z_s1;
			time_s2   <= time_s1;
			scaled_s3 <= atc_pkg::PROD_W'(sum_s2)
				* atc_pkg::PROD_W'(atc_pkg::SCALE_START);
			time_s3   <= time_s2;
		end
	end

	always_comb begin
		scaled_end = scaled_s3 << atc_pkg::END_SHIFT;
		over       = scaled_s3 > bounds.over_sq;
		under      = bounds.under_en && (scaled_s3 < bounds.under_sq);
		below_hi   = scaled_end < bounds.end_hi_sq;
		above_lo   = !bounds.end_lo_en || (scaled_end > bounds.end_lo_sq);

		cls.start_cand = over || under;
		cls.end_cand   = below_hi && above_lo;
		cls.time_ms    = time_s3;
	end

	assign cls_push = v_s3 && en;

endmodule

>>> rtl/atc_back.sv
// Back stage: tap state, cooldown and duration checks, result formation.
module atc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  atc_pkg::cls_t     cls,
	input  logic              cls_empty,
	output logic              cls_pop,
	input  atc_pkg::timing_t  timing,
	output logic              res_push,
	output atc_pkg::result_t  res,
	input  logic              res_full
);
	logic                          in_tap_q;
	logic [atc_pkg::TIME_BITS-1:0] last_end_q;
	logic [atc_pkg::TIME_BITS-1:0] begin_q;

	logic                          fire;
	logic [atc_pkg::TIME_BITS-1:0] since_end;
	logic [atc_pkg::TIME_BITS-1:0] dur;
	logic                          start;
	logic                          tap_now;
	logic                          ending;

	assign fire     = !cls_empty && !res_full;
	assign cls_pop  = fire;
	assign res_push = fire;

	always_comb begin
		since_end = cls.time_ms - last_end_q;
		start     = !in_tap_q && cls.start_cand
			&& (since_end > atc_pkg::TIME_BITS'(timing.cooldown_ms));
		tap_now   = in_tap_q || start;
		ending    = tap_now && cls.end_cand;
		// a tap that starts and ends on one word lasts zero
		dur       = start ? '0 : (cls.time_ms - begin_q);

		res.tap_done   = ending;
		res.tap_short  = ending && (dur < atc_pkg::TIME_BITS'(timing.long_tap_ms));
		res.tap_active = tap_now && !ending;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tap_q   <= 1'b0;
			last_end_q <= '0;
			begin_q    <= '0;
		end else if (fire) begin
			in_tap_q <= tap_now && !ending;
			if (start) begin
				begin_q <= cls.time_ms;
			end
			if (ending) begin
				last_end_q <= cls.time_ms;
			end
		end
	end

endmodule

>>> sim/tb_accel_tap_classifier.sv
// Self-checking testbench for the accelerometer tap classifier, with its own tap predictor.
module tb_accel_tap_classifier;
	import atc_pkg::*;

	localparam int     CYCLE_LIMIT = 400000;
	localparam longint MG_SCALE    = longint'(1) << MG_SHIFT;
	// raw counts per mg: full scale of one axis is 4000 mg
	localparam real    COUNTS_PER_MG = (2.0 ** (SAMPLE_BITS - 1)) / 4000.0;

	typedef enum logic [1:0] {
		MAG_REST,
		MAG_MID,
		MAG_SPIKE
	} mag_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	sample_t               sample = '0;
	logic                  full;
	logic                  empty;
	logic                  pop = 1'b0;
	result_t               result;
	logic                  cfg_wr_en = 1'b0;
	cfg_reg_t              cfg_addr = REG_GRAVITY;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Words waiting to be pushed, and tap results owed by the block, oldest first
	sample_t samples_to_send[$];
	result_t results_due[$];
	result_t result_want;

	// Predictor copy of the configuration registers
	logic [GRAV_W-1:0] gravity_cfg   = GRAVITY_RST;
	logic [THR_W-1:0]  threshold_cfg = THRESHOLD_RST;
	logic [COOL_W-1:0] cooldown_cfg  = COOLDOWN_RST;
	logic [LONG_W-1:0] long_tap_cfg  = LONG_TAP_RST;

	// Predictor copy of the tap state
	logic                 tap_open        = 1'b0;
	logic [TIME_BITS-1:0] tap_end_stamp   = '0;
	logic [TIME_BITS-1:0] tap_begin_stamp = '0;

	logic [TIME_BITS-1:0] stamp = '0;
	int                   send_gap_pct   = 0;
	int                   recv_stall_pct = 0;
	int                   mismatches     = 0;
	int                   cycles         = 0;

	accel_tap_classifier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Classify one sample against the current registers and advance the tap state.
	// Magnitudes stay squared: s * 15625 against (bound)^2 for a start, and
	// s * 62500 against (2 * bound)^2 for the half-threshold end band.
	function automatic result_t classify_tap(sample_t smp);
		longint               ax, ay, az, sq, s1, s2, g, t, hi, lo, hi2, lo2;
		logic                 over, under, below_hi, above_lo;
		logic [TIME_BITS-1:0] dt, dur;
		result_t              res;
		ax = smp.accel_x;
		ay = smp.accel_y;
		az = smp.accel_z;
		sq = ax * ax + ay * ay + az * az;
		s1 = sq * 15625;
		s2 = sq * 62500;
		g  = gravity_cfg;
		t  = threshold_cfg;
		res = '0;
		if (!tap_open) begin
			hi    = g + t;
			lo    = g - t;
			over  = s1 > hi * hi * MG_SCALE;
			under = (g > t) && (s1 < lo * lo * MG_SCALE);
			dt    = smp.time_ms - tap_end_stamp;
			if ((over || under) && dt > TIME_BITS'(cooldown_cfg)) begin
				tap_open        = 1'b1;
				tap_begin_stamp = smp.time_ms;
			end
		end
		if (tap_open) begin
			hi2      = 2 * g + t;
			lo2      = 2 * g - t;
			below_hi = s2 < hi2 * hi2 * MG_SCALE;
			// end band reaches below zero: any magnitude clears the lower edge
			above_lo = (2 * g < t) ? 1'b1 : (s2 > lo2 * lo2 * MG_SCALE);
			if (below_hi && above_lo) begin
				dur           = smp.time_ms - tap_begin_stamp;
				res.tap_done  = 1'b1;
				res.tap_short = dur < TIME_BITS'(long_tap_cfg);
				tap_open      = 1'b0;
				tap_end_stamp = smp.time_ms;
			end
		end
		res.tap_active = tap_open;
		return res;
	endfunction

	function automatic real frac();
		return $urandom_range(0, 1000) / 1000.0;
	endfunction

	// Pick a magnitude in mg relative to the current gravity and threshold
	function automatic real pick_mg(mag_kind_t kind);
		real g, t, dev;
		g = gravity_cfg;
		t = threshold_cfg;
		case (kind)
			MAG_REST: begin
				return g + (frac() - 0.5) * 0.9 * t;
			end
			MAG_MID: begin
				dev = t * (0.55 + 0.4 * frac());
				if (g > dev && $urandom_range(0, 1)) return g - dev;
				return g + dev;
			end
			default: begin
				if (g > t && $urandom_range(0, 1)) return (g - t) * 0.9 * frac();
				return (g + t) * (1.05 + 0.6 * frac()) + 2.0;
			end
		endcase
	endfunction

	// Step the sample clock; now and then jump far so that differences wrap
	function automatic logic [TIME_BITS-1:0] advance_stamp(int span);
		stamp = stamp + $urandom_range(0, span);
		if ($urandom_range(0, 39) == 0) stamp = stamp + $urandom();
		return stamp;
	endfunction

	task automatic add_sample(input logic [15:0] x, y, z, input logic [TIME_BITS-1:0] ts);
		samples_to_send.push_back(sample_t'{x, y, z, ts});
	endtask

	// Queue a vector of the given magnitude in a random direction
	task automatic push_mag(input real mg, input logic [TIME_BITS-1:0] ts);
		real                dir[3];
		real                norm, counts, c;
		int                 v;
		logic signed [15:0] axis[3];
		for (int i = 0; i < 3; i++) dir[i] = frac() * 2.0 - 1.0;
		norm = $sqrt(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
		if (norm < 0.05) begin
			dir  = '{1.0, 0.0, 0.0};
			norm = 1.0;
		end
		counts = (mg < 0.0 ? 0.0 : mg) * COUNTS_PER_MG;
		for (int i = 0; i < 3; i++) begin
			c = dir[i] / norm * counts;
			v = (c >= 0.0) ? $rtoi(c + 0.5) : -$rtoi(0.5 - c);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			axis[i] = v[15:0];
		end
		add_sample(axis[0], axis[1], axis[2], ts);
	endtask

	// Queue tap episodes with random content, mixed with raw noise words
	task automatic add_tap_traffic(input int count);
		int start, rest_span, tap_span;
		start     = samples_to_send.size();
		rest_span = 2 * int'(cooldown_cfg) + 2;
		tap_span  = int'(long_tap_cfg) / 2 + 2;
		while (samples_to_send.size() - start < count) begin
			if ($urandom_range(0, 99) < 12) begin
				add_sample(16'($urandom()), 16'($urandom()), 16'($urandom()),
					$urandom_range(0, 1) ? $urandom() : advance_stamp(rest_span));
			end else begin
				repeat ($urandom_range(0, 2)) push_mag(pick_mg(MAG_REST), advance_stamp(rest_span));
				push_mag(pick_mg(MAG_SPIKE), advance_stamp(rest_span));
				repeat ($urandom_range(0, 3))
					push_mag(pick_mg($urandom_range(0, 1) ? MAG_MID : MAG_SPIKE),
						advance_stamp(tap_span));
				// leave some taps unfinished
				if ($urandom_range(0, 9) != 0) push_mag(pick_mg(MAG_REST), advance_stamp(tap_span));
			end
		end
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_GRAVITY:   gravity_cfg   = val[GRAV_W-1:0];
			REG_THRESHOLD: threshold_cfg = val[THR_W-1:0];
			REG_COOLDOWN:  cooldown_cfg  = val[COOL_W-1:0];
			REG_LONG_TAP:  long_tap_cfg  = val[LONG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] grav, thr, cool, lng);
		write_register(REG_GRAVITY, grav);
		write_register(REG_THRESHOLD, thr);
		write_register(REG_COOLDOWN, cool);
		write_register(REG_LONG_TAP, lng);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Hold until every queued word is in and every result is out, then let the pipe settle
	task automatic wait_for_drain();
		do @(negedge clk);
		while (samples_to_send.size() != 0 || push || results_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	// Sender: hold a word until accepted, predict it on acceptance, insert random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) results_due.push_back(classify_tap(sample));
			if (!push || !full) begin
				if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					push   <= 1'b1;
					sample <= samples_to_send.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each popped word against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected word done=%b short=%b active=%b", $time,
						result.tap_done, result.tap_short, result.tap_active);
				end else begin
					result_want = results_due.pop_front();
					if (result.tap_done !== result_want.tap_done
							|| result.tap_short !== result_want.tap_short
							|| result.tap_active !== result_want.tap_active) begin
						mismatches++;
						$display("%0t: expected done=%b short=%b active=%b, got done=%b short=%b active=%b",
							$time, result_want.tap_done, result_want.tap_short,
							result_want.tap_active, result.tap_done, result.tap_short,
							result.tap_active);
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL accel_tap_classifier");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: gravity 1000, threshold 1500, cooldown 200, long 2000
		add_sample(16'h0000, 16'h0000, 16'd8192, 32'd10);      // at rest, idle word
		add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd150);     // first tap still in cooldown from 0
		add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd200);     // cooldown exactly met, not passed
		add_sample(16'd20480, 16'h0000, 16'h0000, 32'd300);    // exactly on the start bound
		add_sample(16'h8000, 16'h8000, 16'h8000, 32'd301);     // most negative axes start a tap
		add_sample(16'd14336, 16'h0000, 16'h0000, 32'd400);    // exactly on the end band edge
		add_sample(16'h0000, 16'h0000, 16'd8192, 32'd500);     // short tap ends
		add_sample(16'h7FFF, 16'h8000, 16'h0000, 32'd600);     // inside cooldown
		add_sample(16'h7FFF, 16'h8000, 16'h0000, 32'd701);     // tap starts
		add_sample(16'd16384, 16'h0000, 16'h0000, 32'd1500);   // between half and full threshold
		add_sample(16'h0000, 16'd8192, 16'h0000, 32'd2701);    // duration equals long: long tap
		add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FF00);
		add_sample(16'h0000, 16'h0000, 16'd8192, 32'h0000_0010); // duration wraps through zero
		add_sample(16'h8000, 16'h7FFF, 16'h8000, 32'd5);       // earlier stamp: huge elapsed time
		add_sample(16'h0000, 16'h0000, 16'hE000, 32'd5);       // zero duration, short
		add_sample(16'h0000, 16'h0000, 16'h0000, 32'd10000);   // low side cannot start here
		add_sample(16'h5555, 16'hAAAA, 16'h0000, 32'hAAAA_5555);
		add_sample(16'h0000, 16'h0000, 16'h0000, 32'hAAAA_5600);
		add_sample(16'h0000, 16'h0000, 16'd8192, 32'hAAAA_5700);
		wait_for_drain();

		// Threshold below gravity; upper bits of the gravity write are dropped
		set_config(16'hFBB8, 16'd1000, 16'd200, 16'd2000);
		add_sample(16'h0000, 16'h0000, 16'h0000, 32'hAAAA_5800); // free fall starts a tap
		add_sample(16'h0000, 16'h0000, 16'd24576, 32'hAAAA_5840);
		wait_for_drain();

		// End band reaching below zero, zero cooldown and long limit
		set_config(16'd500, 16'd1500, 16'd0, 16'd0);
		add_sample(16'h7FFF, 16'h0000, 16'h0000, 32'hAAAA_5880);
		add_sample(16'h0000, 16'h0000, 16'h0000, 32'hAAAA_5880);
		wait_for_drain();

		// Zero threshold: a tap starts and never ends
		set_config(16'd1000, 16'd0, 16'd0, 16'hFFFF);
		add_sample(16'h0000, 16'h0000, 16'd8192, 32'hAAAA_5900);
		add_sample(16'h0000, 16'h0000, 16'd8200, 32'hAAAA_5901);
		add_sample(16'h0000, 16'h0000, 16'd8192, 32'hAAAA_5902);
		wait_for_drain();

		stamp = 32'hAAAA_6000;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(16'd1000, 16'd1500, 16'd200, 16'd2000);
				1: set_config(16'd4000, 16'd4000, 16'd0, 16'hFFFF);
				2: set_config(16'd0, 16'd4095, 16'hFFFF, 16'd0);
				3: set_config(16'hFFFF, 16'd1, 16'd1, 16'd1);
				default: set_config(16'($urandom_range(300, 3000)), 16'($urandom_range(50, 3000)),
					16'($urandom_range(0, 600)), 16'($urandom_range(0, 4000)));
			endcase
			case (ph % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
				default: begin send_gap_pct = 27; recv_stall_pct = 27; end
			endcase
			add_tap_traffic(160);
			// pause the sender until every result of this phase is back
			wait_for_drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("PASS accel_tap_classifier");
		end else begin
			$display("FAIL accel_tap_classifier");
		end
		$finish;
	end

endmodule

>>> accel_tap_classifier.f
rtl/atc_pkg.sv
rtl/atc_fifo.sv
rtl/atc_cfg.sv
rtl/atc_front.sv
rtl/atc_back.sv
rtl/accel_tap_classifier.sv
sim/tb_accel_tap_classifier.sv
